### rtl/bchd_pkg.sv
// Shared types and constants for the button click and hold detector.
package bchd_pkg;

	typedef enum logic [1:0] {
		CMD_TICK  = 2'd0,
		CMD_TAKE  = 2'd1,
		CMD_CLEAR = 2'd2,
		CMD_QUERY = 2'd3
	} cmd_t;

	localparam int unsigned REG_IDX_W = 3;
	localparam logic [REG_IDX_W-1:0] REG_DEBOUNCE = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_HOLD     = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_ACTIVE_LOW = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_WINDOW   = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_TIMEOUT  = 3'd4;

	localparam int unsigned MS_PER_SEC = 1000;
	localparam logic [15:0] DEBOUNCE_MS_RST = 16'd60;
	localparam logic [15:0] HOLD_MS_RST     = 16'd1000;
	localparam logic [15:0] WINDOW_MS_RST   = 16'd400;
	localparam logic [15:0] TIMEOUT_MS_RST  = 16'(10 * MS_PER_SEC);

	localparam logic [7:0]  CLICK_MAX = 8'hFF;
	localparam logic [31:0] HELD_TIME_MAX = 32'hFFFF_FFFF;

	localparam int unsigned OUT_DATA_W = 48;

endpackage

### rtl/button_click_hold_detector_unit.sv
// Button debounce, click counting and long-press detection on millisecond ticks.
// A result appears in the output register in the cycle after its request is taken.
// Throughput: one request per cycle while the output is not stalled; the state update is a single registered pass.
// s_tready stays high while the output register is empty or being drained.
// Reset clears all state but the output data, expires all timers and loads the register defaults.
module button_click_hold_detector_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [0] pin_level, [7:1] zero
	input  logic [1:0]  s_tuser,   // [1:0] cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // [0] pressed_out, [1] held_out, [9:2] clicks_out,
	                               // [41:10] held_time_ms, [47:42] zero
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	// configuration
	logic [15:0] debounce_ms_q, hold_ms_q, window_ms_q, timeout_ms_q;
	logic        active_low_q;

	// state
	logic        pressed_q, held_q, next_click_q, hold_started_q;
	logic [7:0]  click_count_q;
	logic [15:0] debounce_left_q, hold_left_q, window_left_q, timeout_left_q;
	logic [31:0] hold_elapsed_q;

	logic        m_valid_q;
	logic [bchd_pkg::OUT_DATA_W-1:0] m_data_q;

	// next state
	logic        pressed_d, held_d, next_click_d, hold_started_d;
	logic [7:0]  click_count_d, clicks;
	logic [15:0] debounce_left_d, hold_left_d, window_left_d, timeout_left_d;
	logic [31:0] hold_elapsed_d, held_time;
	logic        p, accept, pressed_res;
	bchd_pkg::cmd_t cmd;

	assign cfg_ready = 1'b1;
	assign s_tready  = !m_valid_q || m_tready;
	assign accept    = s_tvalid && s_tready;
	assign cmd       = bchd_pkg::cmd_t'(s_tuser);
	assign p         = s_tdata[0] ^ active_low_q;
	assign m_tvalid  = m_valid_q;
	assign m_tdata   = m_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_ms_q <= bchd_pkg::DEBOUNCE_MS_RST;
			hold_ms_q     <= bchd_pkg::HOLD_MS_RST;
			active_low_q  <= 1'b0;
			window_ms_q   <= bchd_pkg::WINDOW_MS_RST;
			timeout_ms_q  <= bchd_pkg::TIMEOUT_MS_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				bchd_pkg::REG_DEBOUNCE:   debounce_ms_q <= cfg_data;
				bchd_pkg::REG_HOLD:       hold_ms_q     <= cfg_data;
				bchd_pkg::REG_ACTIVE_LOW: active_low_q  <= cfg_data[0];
				bchd_pkg::REG_WINDOW:     window_ms_q   <= cfg_data;
				bchd_pkg::REG_TIMEOUT:    timeout_ms_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		pressed_d       = pressed_q;
		held_d          = held_q;
		next_click_d    = next_click_q;
		hold_started_d  = hold_started_q;
		click_count_d   = click_count_q;
		debounce_left_d = debounce_left_q;
		hold_left_d     = hold_left_q;
		window_left_d   = window_left_q;
		timeout_left_d  = timeout_left_q;
		hold_elapsed_d  = hold_elapsed_q;
		clicks          = '0;
		held_time       = '0;

		case (cmd)
			bchd_pkg::CMD_TICK: begin
				// advance every timer by one millisecond
				if (debounce_left_q != '0) debounce_left_d = debounce_left_q - 16'd1;
				if (hold_left_q != '0)     hold_left_d     = hold_left_q - 16'd1;
				if (window_left_q != '0)   window_left_d   = window_left_q - 16'd1;
				if (timeout_left_q != '0)  timeout_left_d  = timeout_left_q - 16'd1;
				if (hold_started_q && hold_elapsed_q != bchd_pkg::HELD_TIME_MAX)
					hold_elapsed_d = hold_elapsed_q + 32'd1;

				if (debounce_left_d == '0) begin
					if (click_count_q != '0 && !next_click_q) begin
						// click pending: restart hold, look for the next press
						hold_left_d    = hold_ms_q;
						hold_elapsed_d = '0;
						hold_started_d = 1'b1;
						pressed_d      = p;
						if (p) begin
							debounce_left_d = debounce_ms_q;
							window_left_d   = window_ms_q;
							next_click_d    = 1'b1;
						end
						if (timeout_left_d == '0) begin
							debounce_left_d = debounce_ms_q;
							click_count_d   = '0;
						end
					end else if (held_q) begin
						pressed_d = p;
						if (!p) begin
							debounce_left_d = debounce_ms_q;
							held_d          = 1'b0;
						end
					end else if (pressed_q) begin
						if (!p) begin
							// release: count the click
							timeout_left_d = timeout_ms_q;
							hold_left_d    = hold_ms_q;
							hold_elapsed_d = '0;
							hold_started_d = 1'b1;
							window_left_d  = window_ms_q;
							next_click_d   = 1'b0;
							if (click_count_q != bchd_pkg::CLICK_MAX)
								click_count_d = click_count_q + 8'd1;
						end else if (hold_left_d == '0) begin
							held_d = 1'b1;
						end
						pressed_d = p;
					end else begin
						debounce_left_d = debounce_ms_q;
						hold_left_d     = hold_ms_q;
						hold_elapsed_d  = '0;
						hold_started_d  = 1'b1;
						pressed_d       = p;
						click_count_d   = '0;
						held_d          = 1'b0;
						if (p) window_left_d = window_ms_q;
					end
				end
			end
			bchd_pkg::CMD_TAKE: begin
				if (window_left_q == '0) begin
					clicks        = click_count_q;
					click_count_d = '0;
				end
			end
			bchd_pkg::CMD_CLEAR: begin
				click_count_d   = '0;
				held_d          = 1'b0;
				pressed_d       = 1'b0;
				debounce_left_d = '0;
				window_left_d   = '0;
				hold_left_d     = '0;
				hold_elapsed_d  = '0;
				hold_started_d  = 1'b0;
			end
			bchd_pkg::CMD_QUERY: begin
				if (!p) begin
					hold_left_d    = '0;
					hold_elapsed_d = '0;
					hold_started_d = 1'b0;
					held_d         = 1'b0;
				end else begin
					if (hold_left_q == '0) held_d = 1'b1;
					held_time = hold_started_q ? hold_elapsed_q : '0;
				end
			end
			default: ;
		endcase

		pressed_res = (debounce_left_d != '0) ? pressed_d : p;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pressed_q       <= 1'b0;
			held_q          <= 1'b0;
			next_click_q    <= 1'b0;
			hold_started_q  <= 1'b0;
			click_count_q   <= '0;
			debounce_left_q <= '0;
			hold_left_q     <= '0;
			window_left_q   <= '0;
			timeout_left_q  <= '0;
			hold_elapsed_q  <= '0;
		end else if (accept) begin
			pressed_q       <= pressed_d;
			held_q          <= held_d;
			next_click_q    <= next_click_d;
			hold_started_q  <= hold_started_d;
			click_count_q   <= click_count_d;
			debounce_left_q <= debounce_left_d;
			hold_left_q     <= hold_left_d;
			window_left_q   <= window_left_d;
			timeout_left_q  <= timeout_left_d;
			hold_elapsed_q  <= hold_elapsed_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (accept) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			m_data_q <= {6'd0, held_time, clicks, held_d, pressed_res};
		end
	end

	// clear wipes the click count and the held flag
	a_clear_wipes: assert property (@(posedge clk) disable iff (!arst_n)
		accept && cmd == bchd_pkg::CMD_CLEAR |=> click_count_q == '0 && !held_q)
		else $error("clear did not wipe clicks or held flag");

	// only a query with the button pressed reports a held time
	a_held_time_query_only: assert property (@(posedge clk) disable iff (!arst_n)
		accept && cmd != bchd_pkg::CMD_QUERY |=> m_tvalid && m_tdata[41:10] == '0)
		else $error("held time reported outside a query");

	// taking clicks while the window runs returns zero and keeps the count
	a_take_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		accept && cmd == bchd_pkg::CMD_TAKE && window_left_q != '0
		|=> m_tdata[9:2] == '0 && $stable(click_count_q))
		else $error("clicks taken while the click window runs");

	// a pending result must not be overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("pending result lost");

endmodule

### tb/button_report_checker.sv
// Checker for the button detector: predicts each report and compares it with the output stream.
module button_report_checker
	import bchd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,   // [0] pin_level, [7:1] zero
	input  logic [1:0]  s_tuser,   // [1:0] cmd
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [47:0] m_tdata,   // [0] pressed_out, [1] held_out, [9:2] clicks_out,
	                               // [41:10] held_time_ms, [47:42] zero
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output int unsigned mismatches,
	output int unsigned in_flight,
	output int unsigned compared
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [31:0] held_time;
		logic [7:0]  clicks;
		logic        held;
		logic        pressed;
	} report_t;

	logic [15:0] debounce_ms, hold_ms, window_ms, timeout_ms;
	logic        invert_pin;

	logic        pressed_q, held_q, next_click_q, hold_running;
	logic [7:0]  click_cnt;
	logic [15:0] debounce_cnt, hold_cnt, window_cnt, timeout_cnt;
	logic [31:0] held_ms_cnt;

	report_t     pending_reports[$];
	int unsigned errors = 0;
	int unsigned n_compared = 0;

	function automatic logic [15:0] count_down(logic [15:0] v);
		return (v != 16'd0) ? v - 16'd1 : 16'd0;
	endfunction

	task automatic restart_hold();
		hold_cnt = hold_ms;
		held_ms_cnt = '0;
		hold_running = 1'b1;
	endtask

	task automatic stop_hold();
		hold_cnt = '0;
		held_ms_cnt = '0;
		hold_running = 1'b0;
	endtask

	task automatic reset_model();
		debounce_ms = DEBOUNCE_MS_RST;
		hold_ms = HOLD_MS_RST;
		invert_pin = 1'b0;
		window_ms = WINDOW_MS_RST;
		timeout_ms = TIMEOUT_MS_RST;
		pressed_q = 1'b0;
		held_q = 1'b0;
		next_click_q = 1'b0;
		click_cnt = '0;
		debounce_cnt = '0;
		window_cnt = '0;
		timeout_cnt = '0;
		stop_hold();
	endtask

	// One millisecond: count the timers down, then run one branch unless still debouncing.
	task automatic tick_ms(logic p);
		debounce_cnt = count_down(debounce_cnt);
		hold_cnt = count_down(hold_cnt);
		window_cnt = count_down(window_cnt);
		timeout_cnt = count_down(timeout_cnt);
		if (hold_running && held_ms_cnt != HELD_TIME_MAX)
			held_ms_cnt = held_ms_cnt + 32'd1;
		if (debounce_cnt == 16'd0) begin
			if (click_cnt != 8'd0 && !next_click_q) begin
				restart_hold();
				pressed_q = p;
				if (p) begin
					debounce_cnt = debounce_ms;
					window_cnt = window_ms;
					next_click_q = 1'b1;
				end
				// drop pending clicks once the timeout has run out
				if (timeout_cnt == 16'd0) begin
					debounce_cnt = debounce_ms;
					click_cnt = '0;
				end
			end else if (held_q) begin
				pressed_q = p;
				if (!p) begin
					debounce_cnt = debounce_ms;
					held_q = 1'b0;
				end
			end else if (pressed_q) begin
				if (!p) begin
					timeout_cnt = timeout_ms;
					restart_hold();
					window_cnt = window_ms;
					next_click_q = 1'b0;
					if (click_cnt != CLICK_MAX)
						click_cnt = click_cnt + 8'd1;
				end else if (hold_cnt == 16'd0) begin
					held_q = 1'b1;
				end
				pressed_q = p;
			end else begin
				debounce_cnt = debounce_ms;
				restart_hold();
				pressed_q = p;
				click_cnt = '0;
				held_q = 1'b0;
				if (p)
					window_cnt = window_ms;
			end
		end
	endtask

	task automatic apply_request(input cmd_t c, input logic pin, output report_t r);
		logic p;
		p = pin ^ invert_pin;
		r = '0;
		case (c)
			CMD_TICK: tick_ms(p);
			CMD_TAKE: begin
				if (window_cnt == 16'd0) begin
					r.clicks = click_cnt;
					click_cnt = '0;
				end
			end
			CMD_CLEAR: begin
				click_cnt = '0;
				held_q = 1'b0;
				pressed_q = 1'b0;
				debounce_cnt = '0;
				window_cnt = '0;
				stop_hold();
			end
			default: begin
				if (!p) begin
					stop_hold();
					held_q = 1'b0;
				end else begin
					if (hold_cnt == 16'd0)
						held_q = 1'b1;
					r.held_time = hold_running ? held_ms_cnt : '0;
				end
			end
		endcase
		r.pressed = (debounce_cnt != 16'd0) ? pressed_q : p;
		r.held = held_q;
	endtask

	task automatic write_setting(logic [2:0] idx, logic [15:0] val);
		case (idx)
			REG_DEBOUNCE:   debounce_ms = val;
			REG_HOLD:       hold_ms = val;
			REG_ACTIVE_LOW: invert_pin = val[0];
			REG_WINDOW:     window_ms = val;
			REG_TIMEOUT:    timeout_ms = val;
			default: ;
		endcase
	endtask

	task automatic note_mismatch(string fields, report_t want, report_t got);
		errors++;
		if (errors <= 10)
			$display("report mismatch on%s: ", fields,
				"expected pressed=%0b held=%0b clicks=%0d held_time=%0d, ",
				want.pressed, want.held, want.clicks, want.held_time,
				"got pressed=%0b held=%0b clicks=%0d held_time=%0d",
				got.pressed, got.held, got.clicks, got.held_time);
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		report_t want, got, next_report;
		string   fields;
		if (!arst_n) begin
			reset_model();
			pending_reports.delete();
			in_flight <= 0;
		end else begin
			// retire the output first: a request taken at this edge cannot answer at it
			if (m_tvalid && m_tready) begin
				got = report_t'(m_tdata[41:0]);
				if (pending_reports.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("report with no request waiting: %h", m_tdata);
				end else begin
					want = pending_reports.pop_front();
					n_compared++;
					fields = "";
					if (got.pressed !== want.pressed)
						fields = {fields, " pressed"};
					if (got.held !== want.held)
						fields = {fields, " held"};
					if (got.clicks !== want.clicks)
						fields = {fields, " clicks"};
					if (got.held_time !== want.held_time)
						fields = {fields, " held_time"};
					if (m_tdata[47:42] !== '0)
						fields = {fields, " padding"};
					if (fields != "")
						note_mismatch(fields, want, got);
				end
			end
			if (cfg_valid && cfg_ready)
				write_setting(cfg_index, cfg_data);
			if (s_tvalid && s_tready) begin
				apply_request(cmd_t'(s_tuser), s_tdata[0], next_report);
				pending_reports.push_back(next_report);
			end
			in_flight <= pending_reports.size();
		end
		mismatches <= errors;
		compared <= n_compared;
	end

endmodule

### tb/testbench.sv
// Top of the button detector testbench: drives requests and settings and gives the verdict.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import bchd_pkg::*;

	localparam int unsigned ITEM_GOAL = 1750;
	localparam logic [2:0] REG_SPARE = REG_TIMEOUT + 3'd1;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic [1:0]  s_tuser = CMD_TICK;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = REG_DEBOUNCE;
	logic [15:0] cfg_data = '0;

	int unsigned mismatches, in_flight, compared;
	int unsigned n_items = 0;
	int unsigned n_writes = 0;
	int unsigned cur_deb, cur_hold, cur_win, cur_tmo;
	logic        invert = 1'b0;
	logic        steady = 1'b0;

	button_click_hold_detector_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	button_report_checker i_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.mismatches (mismatches),
		.in_flight  (in_flight),
		.compared   (compared)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		m_tready <= steady || ($urandom_range(99) >= 21);
	end

	initial begin
		#20ms;
		$display("simulation failed");
		$finish;
	end

	task automatic send(cmd_t c, logic pin);
		if (!steady && $urandom_range(99) < 27) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= c;
		s_tdata <= {7'd0, pin};
		do @(posedge clk); while (!s_tready);
		n_items++;
	endtask

	// level is the qualified press state; map it to the raw pin
	task automatic tick(logic level);
		send(CMD_TICK, level ^ invert);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (in_flight != 0);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		n_writes++;
	endtask

	task automatic configure(logic [15:0] deb, logic [15:0] hold, logic al,
			logic [15:0] win, logic [15:0] tmo);
		drain();
		write_reg(REG_DEBOUNCE, deb);
		write_reg(REG_HOLD, hold);
		write_reg(REG_ACTIVE_LOW, {15'($urandom), al});
		write_reg(REG_WINDOW, win);
		write_reg(REG_TIMEOUT, tmo);
		if ($urandom_range(3) == 0)
			write_reg(REG_SPARE + 3'($urandom_range(2)), 16'($urandom));
		cfg_valid <= 1'b0;
		invert = al;
		cur_deb = deb;
		cur_hold = hold;
		cur_win = win;
		cur_tmo = tmo;
	endtask

	function automatic logic [15:0] pick_ms(int unsigned span, int unsigned full_pct);
		int unsigned r;
		r = $urandom_range(99);
		if (r < full_pct)
			return 16'hFFFF;
		if (r < full_pct + 15)
			return 16'd0;
		return 16'($urandom_range(span));
	endfunction

	function automatic int unsigned cap(int unsigned n);
		return (n > 60) ? 60 : n;
	endfunction

	function automatic int unsigned run_len(int unsigned n);
		return $urandom_range(cap(n), 1);
	endfunction

	task automatic side_request(logic level);
		int unsigned r;
		logic        pin;
		r = $urandom_range(99);
		pin = ($urandom_range(3) == 0) ? 1'($urandom) : level ^ invert;
		if (r < 45)
			send(CMD_TAKE, pin);
		else if (r < 90)
			send(CMD_QUERY, pin);
		else
			send(CMD_CLEAR, pin);
	endtask

	task automatic hold_level(logic level, int unsigned len);
		int unsigned k;
		for (k = 0; k < len; k++) begin
			tick(level);
			if ($urandom_range(99) < 6)
				side_request(level);
		end
	endtask

	// Mostly well-formed presses and releases sized to the current delays, plus noise.
	task automatic gesture_phase(int unsigned budget);
		int unsigned goal, r, k, n;
		goal = n_items + budget;
		while (n_items < goal) begin
			r = $urandom_range(99);
			if (r < 50) begin
				hold_level(1'b1, run_len(cur_deb + cur_hold / 2 + 2));
				hold_level(1'b0, run_len(cur_deb + cur_win + 3));
			end else if (r < 65) begin
				hold_level(1'b1, cap(cur_deb + cur_hold + $urandom_range(4)));
				hold_level(1'b0, run_len(cur_deb + 3));
			end else if (r < 75) begin
				hold_level(1'b0, cap(cur_deb + cur_tmo + 2));
			end else if (r < 90) begin
				n = $urandom_range(6, 1);
				for (k = 0; k < n; k++)
					send(CMD_TICK, 1'($urandom));
			end else begin
				side_request(1'($urandom));
			end
		end
	endtask

	initial begin
		int unsigned phase;
		int unsigned k;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset defaults: a query and a take first, then a tick that starts the long debounce, a press inside it
		cur_deb = DEBOUNCE_MS_RST;
		cur_hold = HOLD_MS_RST;
		cur_win = WINDOW_MS_RST;
		cur_tmo = TIMEOUT_MS_RST;
		send(CMD_QUERY, 1'b0);
		send(CMD_TAKE, 1'b1);
		tick(1'b0);
		tick(1'b1);
		send(CMD_CLEAR, 1'b1);

		// no debounce, short hold: reach held, query it, release, one click, take it
		configure(16'd0, 16'd2, 1'b0, 16'd0, 16'hFFFF);
		@(posedge clk);
		write_reg(REG_SPARE, 16'hFFFF);
		cfg_valid <= 1'b0;
		repeat (4) tick(1'b1);
		send(CMD_QUERY, 1'b1);
		tick(1'b0);
		tick(1'b1);
		tick(1'b0);
		send(CMD_TAKE, 1'b0);

		// active low, zero timeout: take inside the window, then the clicks drop
		configure(16'd0, 16'hFFFF, 1'b1, 16'd3, 16'd0);
		tick(1'b1);
		tick(1'b0);
		send(CMD_TAKE, 1'b0);
		tick(1'b1);
		send(CMD_QUERY, 1'b1);
		send(CMD_QUERY, 1'b0);

		// full-scale debounce holds the stored press until a clear
		configure(16'hFFFF, 16'd0, 1'b0, 16'hFFFF, 16'hFFFF);
		tick(1'b1);
		tick(1'b0);
		tick(1'b1);
		send(CMD_CLEAR, 1'b0);
		tick(1'b1);

		// click flood without idling: saturate the count, then take it after the window
		steady <= 1'b1;
		configure(16'd0, 16'hFFFF, 1'($urandom), 16'd2, 16'hFFFF);
		send(CMD_CLEAR, 1'b0 ^ invert);
		tick(1'b0);
		tick(1'b0);
		for (k = 0; k < 270; k++) begin
			tick(1'b1);
			tick(1'b0);
		end
		repeat (3) tick(1'b0);
		send(CMD_TAKE, 1'($urandom));
		steady <= 1'b0;

		phase = 0;
		while (n_items < ITEM_GOAL) begin
			configure(pick_ms(4, 2), pick_ms(12, 5), 1'($urandom), pick_ms(8, 5),
				pick_ms(30, 10));
			if (phase == 1)
				steady <= 1'b1;
			gesture_phase(75);
			// hold off until the detector has answered everything
			if (phase == 2)
				drain();
			gesture_phase(75);
			drain();
			steady <= 1'b0;
			phase++;
		end

		drain();
		$display("ran %0d requests through %0d register writes, %0d reports compared",
			n_items, n_writes, compared);
		$display("settings spanned zero and full-scale delays and both pin polarities");
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

### files.f
rtl/bchd_pkg.sv
rtl/button_click_hold_detector_unit.sv
tb/button_report_checker.sv
tb/testbench.sv
